// ===== design/atan2_heading_approx_unit_macros.svh =====
// assertion helpers shared by the heading datapath modules
`ifndef ATAN2_HEADING_APPROX_UNIT_MACROS_SVH
`define ATAN2_HEADING_APPROX_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ATAN2_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("atan2 heading check failed");

// next-cycle implication, checked outside reset
`define ATAN2_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("atan2 heading check failed");

`endif

// ===== design/atan2h_pkg.sv =====
// ----------------------------------------------------------------------------
// atan2h_pkg
// Shared widths, constants and sideband type of the heading datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package atan2h_pkg;

    // component and angle resolution
    localparam int COMPONENT_WIDTH     = 16;
    localparam int ANGLE_FRACTION_BITS = 6;

    // ratio t = T / 2^RATIO_FRAC, T in 0..2^RATIO_FRAC
    localparam int RATIO_FRAC = 16;
    localparam int T_W        = RATIO_FRAC + 1;

    // octant angle is carried in units of 2^-SHIFT_TOTAL degree
    localparam int SHIFT_TOTAL = 2 * RATIO_FRAC + 1;

    localparam int MAG_W  = COMPONENT_WIDTH;
    localparam int REM_W  = MAG_W + 1;
    localparam int PROD_W = 2 * RATIO_FRAC + 1;
    localparam int LIN_W  = T_W + 7;
    localparam int P31_W  = PROD_W + 5;
    localparam int OCT_W  = 6 + SHIFT_TOTAL;
    localparam int ANG_W  = 7 + SHIFT_TOTAL;
    localparam int HX_W   = 9 + SHIFT_TOTAL;

    localparam int ROUND_SHIFT = SHIFT_TOTAL - ANGLE_FRACTION_BITS;
    localparam int RND_W       = HX_W - ROUND_SHIFT;
    localparam int HEADING_W   = $clog2(360 * (1 << ANGLE_FRACTION_BITS));

    // stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = ((2 * COMPONENT_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((HEADING_W + 7) / 8) * 8;

    // axis headings in output units
    localparam logic [HEADING_W-1:0] H_0   = '0;
    localparam logic [HEADING_W-1:0] H_90  = HEADING_W'(90 * (1 << ANGLE_FRACTION_BITS));
    localparam logic [HEADING_W-1:0] H_180 = HEADING_W'(180 * (1 << ANGLE_FRACTION_BITS));
    localparam logic [HEADING_W-1:0] H_270 = HEADING_W'(270 * (1 << ANGLE_FRACTION_BITS));
    localparam logic [RND_W-1:0]     H_FULL = RND_W'(360) << ANGLE_FRACTION_BITS;

    // fine-unit constants
    localparam logic [T_W-1:0]   ONE_T    = T_W'(1) << RATIO_FRAC;
    localparam logic [LIN_W-1:0] LIN_MUL  = LIN_W'(90);
    localparam logic [ANG_W-1:0] FULL_90  = ANG_W'(90) << SHIFT_TOTAL;
    localparam logic [HX_W-1:0]  D180     = HX_W'(180) << SHIFT_TOTAL;
    localparam logic [HX_W-1:0]  D360     = HX_W'(360) << SHIFT_TOTAL;
    localparam logic [HX_W-1:0]  HALF_LSB = HX_W'(1) << (ROUND_SHIFT - 1);

    // per-item control carried alongside the datapath
    typedef struct packed {
        logic                 special;
        logic [HEADING_W-1:0] special_h;
        logic                 mirror;
        logic                 sn_pos;
        logic                 se_pos;
    } t_side;

endpackage

// ===== design/atan2h_prep.sv =====
// ----------------------------------------------------------------------------
// atan2h_prep
// Magnitudes, axis cases and divider operands, one register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atan2h_prep (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [atan2h_pkg::MAG_W-1:0]  i_ns,
    input  logic [atan2h_pkg::MAG_W-1:0]  i_ew,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [atan2h_pkg::MAG_W-1:0]  o_small,
    output logic [atan2h_pkg::MAG_W-1:0]  o_large,
    output atan2h_pkg::t_side             o_side
);

    logic                         r_valid;
    logic [atan2h_pkg::MAG_W-1:0] r_small;
    logic [atan2h_pkg::MAG_W-1:0] r_large;
    atan2h_pkg::t_side            r_side;

    logic [atan2h_pkg::MAG_W-1:0] n_small;
    logic [atan2h_pkg::MAG_W-1:0] n_large;
    atan2h_pkg::t_side            n_side;

    logic [atan2h_pkg::MAG_W-1:0] w_n_mag;
    logic [atan2h_pkg::MAG_W-1:0] w_e_mag;
    logic                         w_ns_neg;
    logic                         w_ew_neg;
    logic                         w_e_lt_n;

    // magnitudes; the most negative value maps to 2^(MAG_W-1) exactly
    assign w_ns_neg = i_ns[atan2h_pkg::MAG_W-1];
    assign w_ew_neg = i_ew[atan2h_pkg::MAG_W-1];
    assign w_n_mag  = w_ns_neg ? (~i_ns) + atan2h_pkg::MAG_W'(1) : i_ns;
    assign w_e_mag  = w_ew_neg ? (~i_ew) + atan2h_pkg::MAG_W'(1) : i_ew;
    assign w_e_lt_n = w_e_mag < w_n_mag;

    // operands and axis handling
    always_comb begin
        n_small          = w_e_lt_n ? w_e_mag : w_n_mag;
        n_large          = w_e_lt_n ? w_n_mag : w_e_mag;
        n_side.special   = (i_ew == '0) || (i_ns == '0);
        n_side.mirror    = !w_e_lt_n;
        n_side.sn_pos    = !w_ns_neg;
        n_side.se_pos    = !w_ew_neg;
        if (i_ew == '0) begin
            n_side.special_h = w_ns_neg ? atan2h_pkg::H_180 : atan2h_pkg::H_0;
        end else begin
            n_side.special_h = w_ew_neg ? atan2h_pkg::H_270 : atan2h_pkg::H_90;
        end
    end

    assign o_ready = !r_valid || i_ready;

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_small <= n_small;
            r_large <= n_large;
            r_side  <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_small = r_small;
    assign o_large = r_large;
    assign o_side  = r_side;

endmodule

// ===== design/atan2h_divider.sv =====
// ----------------------------------------------------------------------------
// atan2h_divider
// Pipelined restoring divider, one quotient bit per stage: T = small*2^16/large.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "atan2_heading_approx_unit_macros.svh"

module atan2h_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [atan2h_pkg::MAG_W-1:0]  i_small,
    input  logic [atan2h_pkg::MAG_W-1:0]  i_large,
    input  atan2h_pkg::t_side             i_side,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [atan2h_pkg::T_W-1:0]    o_quo,
    output atan2h_pkg::t_side             o_side
);

    localparam int NS = atan2h_pkg::T_W;

    logic [NS-1:0]                r_valid;
    logic [atan2h_pkg::REM_W-1:0] r_rem   [NS];
    logic [atan2h_pkg::T_W-1:0]   r_quo   [NS];
    logic [atan2h_pkg::MAG_W-1:0] r_large [NS];
    atan2h_pkg::t_side            r_side  [NS];

    logic [atan2h_pkg::REM_W-1:0] n_rem   [NS];
    logic [atan2h_pkg::T_W-1:0]   n_quo   [NS];
    logic [atan2h_pkg::MAG_W-1:0] n_large [NS];
    atan2h_pkg::t_side            n_side  [NS];
    logic [NS-1:0]                n_valid;

    logic [NS-1:0]                w_ready;

    // one compare and subtract per stage
    always_comb begin
        logic [atan2h_pkg::REM_W-1:0] v_x;
        logic [atan2h_pkg::REM_W-1:0] v_d;
        logic [atan2h_pkg::T_W-1:0]   v_q;
        logic                         v_ge;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                v_x        = {1'b0, i_small};
                v_d        = {1'b0, i_large};
                v_q        = '0;
                n_large[k] = i_large;
                n_side[k]  = i_side;
                n_valid[k] = i_valid;
            end else begin
                v_x        = {r_rem[k-1][atan2h_pkg::REM_W-2:0], 1'b0};
                v_d        = {1'b0, r_large[k-1]};
                v_q        = r_quo[k-1];
                n_large[k] = r_large[k-1];
                n_side[k]  = r_side[k-1];
                n_valid[k] = r_valid[k-1];
            end
            v_ge     = v_x >= v_d;
            n_rem[k] = v_ge ? v_x - v_d : v_x;
            n_quo[k] = {v_q[atan2h_pkg::T_W-2:0], v_ge};
        end
    end

    // per-stage ready so bubbles collapse under a stall
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            if (k == NS - 1) begin
                w_ready[k] = !r_valid[k] || i_ready;
            end else begin
                w_ready[k] = !r_valid[k] || w_ready[k+1];
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_ready[k]) begin
                    r_valid[k] <= n_valid[k];
                end
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (w_ready[k] && n_valid[k]) begin
                r_rem[k]   <= n_rem[k];
                r_quo[k]   <= n_quo[k];
                r_large[k] <= n_large[k];
                r_side[k]  <= n_side[k];
            end
        end
    end

    assign o_ready = w_ready[0];
    assign o_valid = r_valid[NS-1];
    assign o_quo   = r_quo[NS-1];
    assign o_side  = r_side[NS-1];

    // ratio never exceeds one for a real octant item
    `ATAN2_ASSERT_IMPL(a_quo_le_one, i_clk, i_rst_n, r_valid[NS-1] && !r_side[NS-1].special, r_quo[NS-1] <= atan2h_pkg::ONE_T)
    // restoring remainder stays below the divisor
    `ATAN2_ASSERT_IMPL(a_rem_lt_div, i_clk, i_rst_n, r_valid[NS-1] && !r_side[NS-1].special, r_rem[NS-1] < {1'b0, r_large[NS-1]})

endmodule

// ===== design/atan2h_poly.sv =====
// ----------------------------------------------------------------------------
// atan2h_poly
// Octant angle 90*2^16*T + 31*T*(2^16-T) and the 45 degree mirror, four stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atan2h_poly (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [atan2h_pkg::T_W-1:0]    i_quo,
    input  atan2h_pkg::t_side             i_side,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [atan2h_pkg::ANG_W-1:0]  o_ang,
    output atan2h_pkg::t_side             o_side
);

    logic [3:0]                   r_valid;
    logic [3:0]                   w_ready;

    logic [atan2h_pkg::PROD_W-1:0] r_prod;
    logic [atan2h_pkg::LIN_W-1:0]  r_lin1;
    atan2h_pkg::t_side             r_side1;
    logic [atan2h_pkg::P31_W-1:0]  r_p31;
    logic [atan2h_pkg::LIN_W-1:0]  r_lin2;
    atan2h_pkg::t_side             r_side2;
    logic [atan2h_pkg::OCT_W-1:0]  r_oct;
    atan2h_pkg::t_side             r_side3;
    logic [atan2h_pkg::ANG_W-1:0]  r_ang;
    atan2h_pkg::t_side             r_side4;

    logic [atan2h_pkg::PROD_W-1:0] n_prod;
    logic [atan2h_pkg::LIN_W-1:0]  n_lin1;
    logic [atan2h_pkg::P31_W-1:0]  n_p31;
    logic [atan2h_pkg::OCT_W-1:0]  n_oct;
    logic [atan2h_pkg::ANG_W-1:0]  n_ang;

    logic [atan2h_pkg::T_W-1:0]    w_comp;
    logic [2*atan2h_pkg::T_W-1:0]  w_full;

    // stage 1: T*(2^16-T) product and linear term 90*T
    assign w_comp = atan2h_pkg::ONE_T - i_quo;
    assign w_full = i_quo * w_comp;
    assign n_prod = w_full[atan2h_pkg::PROD_W-1:0];
    assign n_lin1 = atan2h_pkg::LIN_W'(i_quo) * atan2h_pkg::LIN_MUL;

    // stage 2: times 31 as shift and subtract
    assign n_p31 = (atan2h_pkg::P31_W'(r_prod) << 5) - atan2h_pkg::P31_W'(r_prod);

    // stage 3: octant angle
    assign n_oct = (atan2h_pkg::OCT_W'(r_lin2) << atan2h_pkg::RATIO_FRAC)
                 + atan2h_pkg::OCT_W'(r_p31);

    // stage 4: mirror about 45 degrees when north-south is not the larger
    assign n_ang = r_side3.mirror ? atan2h_pkg::FULL_90 - atan2h_pkg::ANG_W'(r_oct)
                                  : atan2h_pkg::ANG_W'(r_oct);

    // ready chain
    assign w_ready[3] = !r_valid[3] || i_ready;
    assign w_ready[2] = !r_valid[2] || w_ready[3];
    assign w_ready[1] = !r_valid[1] || w_ready[2];
    assign w_ready[0] = !r_valid[0] || w_ready[1];

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_ready[0]) r_valid[0] <= i_valid;
            if (w_ready[1]) r_valid[1] <= r_valid[0];
            if (w_ready[2]) r_valid[2] <= r_valid[1];
            if (w_ready[3]) r_valid[3] <= r_valid[2];
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_ready[0] && i_valid) begin
            r_prod  <= n_prod;
            r_lin1  <= n_lin1;
            r_side1 <= i_side;
        end
        if (w_ready[1] && r_valid[0]) begin
            r_p31   <= n_p31;
            r_lin2  <= r_lin1;
            r_side2 <= r_side1;
        end
        if (w_ready[2] && r_valid[1]) begin
            r_oct   <= n_oct;
            r_side3 <= r_side2;
        end
        if (w_ready[3] && r_valid[2]) begin
            r_ang   <= n_ang;
            r_side4 <= r_side3;
        end
    end

    assign o_ready = w_ready[0];
    assign o_valid = r_valid[3];
    assign o_ang   = r_ang;
    assign o_side  = r_side4;

endmodule

// ===== design/atan2h_fold.sv =====
// ----------------------------------------------------------------------------
// atan2h_fold
// Quadrant fold, rounding to output units and full-turn wrap, two stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "atan2_heading_approx_unit_macros.svh"

module atan2h_fold (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [atan2h_pkg::ANG_W-1:0]      i_ang,
    input  atan2h_pkg::t_side                 i_side,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [atan2h_pkg::HEADING_W-1:0]  o_heading
);

    logic                             r_hx_valid;
    logic [atan2h_pkg::HX_W-1:0]      r_hx;
    atan2h_pkg::t_side                r_side;
    logic                             r_out_valid;
    logic [atan2h_pkg::HEADING_W-1:0] r_heading;

    logic [atan2h_pkg::HX_W-1:0]      n_hx;
    logic [atan2h_pkg::HEADING_W-1:0] n_heading;

    logic [atan2h_pkg::HX_W-1:0]      w_a;
    logic [atan2h_pkg::HX_W-1:0]      w_sum;
    logic [atan2h_pkg::RND_W-1:0]     w_rnd;
    logic                             w_ready_hx;
    logic                             w_ready_out;

    // quadrant fold from the component signs
    assign w_a = atan2h_pkg::HX_W'(i_ang);
    always_comb begin
        case ({i_side.se_pos, i_side.sn_pos})
            2'b11:   n_hx = w_a;
            2'b10:   n_hx = atan2h_pkg::D180 - w_a;
            2'b01:   n_hx = atan2h_pkg::D360 - w_a;
            default: n_hx = atan2h_pkg::D180 + w_a;
        endcase
    end

    // round half up, wrap a full turn, axis cases override
    assign w_sum = r_hx + atan2h_pkg::HALF_LSB;
    assign w_rnd = w_sum[atan2h_pkg::HX_W-1:atan2h_pkg::ROUND_SHIFT];
    always_comb begin
        if (r_side.special) begin
            n_heading = r_side.special_h;
        end else if (w_rnd >= atan2h_pkg::H_FULL) begin
            n_heading = atan2h_pkg::H_0;
        end else begin
            n_heading = atan2h_pkg::HEADING_W'(w_rnd);
        end
    end

    assign w_ready_out = !r_out_valid || i_ready;
    assign w_ready_hx  = !r_hx_valid || w_ready_out;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hx_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ready_hx)  r_hx_valid  <= i_valid;
            if (w_ready_out) r_out_valid <= r_hx_valid;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_ready_hx && i_valid) begin
            r_hx   <= n_hx;
            r_side <= i_side;
        end
        if (w_ready_out && r_hx_valid) begin
            r_heading <= n_heading;
        end
    end

    assign o_ready   = w_ready_hx;
    assign o_valid   = r_out_valid;
    assign o_heading = r_heading;

    // delivered heading always below a full turn
    `ATAN2_ASSERT_IMPL(a_heading_range, i_clk, i_rst_n, r_out_valid, atan2h_pkg::RND_W'(r_heading) < atan2h_pkg::H_FULL)
    // axis cases only ever carry one of the four compass points
    `ATAN2_ASSERT_IMPL(a_axis_value, i_clk, i_rst_n, r_hx_valid && r_side.special, r_side.special_h == atan2h_pkg::H_0 || r_side.special_h == atan2h_pkg::H_90 || r_side.special_h == atan2h_pkg::H_180 || r_side.special_h == atan2h_pkg::H_270)
    // a rounded item moves to the output register when that register is free
    `ATAN2_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, r_hx_valid && w_ready_out, r_out_valid)

endmodule

// ===== design/atan2_heading_approx_unit.sv =====
// ----------------------------------------------------------------------------
// atan2_heading_approx_unit
// Compass heading from north-south and east-west components.
// ----------------------------------------------------------------------------
// Takes one vector per cycle while the output is not stalled and returns its
// heading clockwise from north in 1/64 degree steps (0..23039), using a
// quadratic arctangent fit on the ratio of the smaller magnitude to the
// larger. Stages: one operand stage, 17 divider stages (one quotient bit
// each, the bulk of the pipeline), four polynomial stages and two
// fold/round stages. Each stage has its own ready, so empty slots fill
// while the output is stalled and results leave in input order.
`timescale 1ns / 1ps

module atan2_heading_approx_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [15:0] north_south, [31:16] east_west
    input  logic [atan2h_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [14:0] heading, upper bits zero
    output logic [atan2h_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    logic                             w_p_valid;
    logic                             w_p_ready;
    logic [atan2h_pkg::MAG_W-1:0]     w_p_small;
    logic [atan2h_pkg::MAG_W-1:0]     w_p_large;
    atan2h_pkg::t_side                w_p_side;

    logic                             w_d_valid;
    logic                             w_d_ready;
    logic [atan2h_pkg::T_W-1:0]       w_d_quo;
    atan2h_pkg::t_side                w_d_side;

    logic                             w_a_valid;
    logic                             w_a_ready;
    logic [atan2h_pkg::ANG_W-1:0]     w_a_ang;
    atan2h_pkg::t_side                w_a_side;

    logic [atan2h_pkg::HEADING_W-1:0] w_heading;

    // operand stage
    atan2h_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_ns    (i_s_axis_tdata[atan2h_pkg::MAG_W-1:0]),
        .i_ew    (i_s_axis_tdata[2*atan2h_pkg::MAG_W-1:atan2h_pkg::MAG_W]),
        .o_valid (w_p_valid),
        .i_ready (w_p_ready),
        .o_small (w_p_small),
        .o_large (w_p_large),
        .o_side  (w_p_side)
    );

    // ratio divider
    atan2h_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_p_valid),
        .o_ready (w_p_ready),
        .i_small (w_p_small),
        .i_large (w_p_large),
        .i_side  (w_p_side),
        .o_valid (w_d_valid),
        .i_ready (w_d_ready),
        .o_quo   (w_d_quo),
        .o_side  (w_d_side)
    );

    // octant polynomial
    atan2h_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d_valid),
        .o_ready (w_d_ready),
        .i_quo   (w_d_quo),
        .i_side  (w_d_side),
        .o_valid (w_a_valid),
        .i_ready (w_a_ready),
        .o_ang   (w_a_ang),
        .o_side  (w_a_side)
    );

    // quadrant fold and rounding, output register
    atan2h_fold u_fold (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_a_valid),
        .o_ready   (w_a_ready),
        .i_ang     (w_a_ang),
        .i_side    (w_a_side),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_heading (w_heading)
    );

    assign o_m_axis_tdata = atan2h_pkg::OUT_TDATA_W'(w_heading);

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream-level bench for the compass heading unit.
// ----------------------------------------------------------------------------
// Vectors go in on the slave stream and headings come back on the master
// stream. A scoreboard computes each expected heading in exact integer
// arithmetic when the input transfer happens, then checks results in order.
// Traffic runs in phases with different sender gaps and receiver stalls,
// including a long receiver hold that backs the pipeline up to its input.
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF_NS     = 4;
    localparam int RESET_CYCLES    = 12;
    localparam int PIPE_LATENCY    = 24;
    localparam int LONG_HOLD       = 400;
    localparam int ITEMS_PER_PHASE = 280;
    localparam int HOLD_ITEMS      = 90;
    localparam longint RUN_LIMIT_NS = 5_000_000;

    // ratio and angle formats
    localparam int RATIO_BITS  = 16;
    localparam int FINE_SHIFT  = 33;
    localparam int ANGLE_FRAC  = 6;
    localparam int ROUND_BITS  = FINE_SHIFT - ANGLE_FRAC;
    localparam bit [63:0] HEADING_EAST  = 64'd90 << ANGLE_FRAC;
    localparam bit [63:0] HEADING_SOUTH = 64'd180 << ANGLE_FRAC;
    localparam bit [63:0] HEADING_WEST  = 64'd270 << ANGLE_FRAC;
    localparam bit [63:0] HEADING_TURN  = 64'd360 << ANGLE_FRAC;

    // shapes of random vectors
    typedef enum int {
        SHAPE_ANY,
        SHAPE_SMALL,
        SHAPE_AXIS,
        SHAPE_NEAR_DIAG,
        SHAPE_EXTREME
    } t_shape;

    // expected headings, checked in arrival order
    class heading_scoreboard;
        bit [14:0]   expected_headings[$];
        int unsigned mismatches;
        int unsigned vectors_noted;
        int unsigned headings_checked;

        function automatic bit [14:0] predict_heading(bit [15:0] ns_raw, bit [15:0] ew_raw);
            bit [63:0] n_mag;
            bit [63:0] e_mag;
            bit [63:0] minor;
            bit [63:0] major;
            bit [63:0] ratio;
            bit [63:0] octant;
            bit [63:0] fine;
            bit [63:0] rounded;
            bit        n_neg;
            bit        e_neg;
            n_neg = ns_raw[15];
            e_neg = ew_raw[15];
            n_mag = n_neg ? (64'h10000 - {48'd0, ns_raw}) : {48'd0, ns_raw};
            e_mag = e_neg ? (64'h10000 - {48'd0, ew_raw}) : {48'd0, ew_raw};
            // axis cases first
            if (e_mag == 0) begin
                rounded = n_neg ? HEADING_SOUTH : 64'd0;
            end else if (n_mag == 0) begin
                rounded = e_neg ? HEADING_WEST : HEADING_EAST;
            end else begin
                minor  = (e_mag < n_mag) ? e_mag : n_mag;
                major  = (e_mag < n_mag) ? n_mag : e_mag;
                ratio  = (minor << RATIO_BITS) / major;
                octant = 64'd90 * 64'd65536 * ratio + 64'd31 * ratio * (64'd65536 - ratio);
                // mirror about 45 degrees unless north-south dominates
                if (!(e_mag < n_mag))
                    octant = (64'd90 << FINE_SHIFT) - octant;
                // quadrant fold
                if (!e_neg)
                    fine = n_neg ? (64'd180 << FINE_SHIFT) - octant : octant;
                else
                    fine = n_neg ? (64'd180 << FINE_SHIFT) + octant
                                 : (64'd360 << FINE_SHIFT) - octant;
                rounded = (fine + (64'd1 << (ROUND_BITS - 1))) >> ROUND_BITS;
                if (rounded >= HEADING_TURN)
                    rounded = 64'd0;
            end
            return rounded[14:0];
        endfunction

        function void note_vector(bit [15:0] ns_raw, bit [15:0] ew_raw);
            expected_headings.push_back(predict_heading(ns_raw, ew_raw));
            vectors_noted++;
        endfunction

        function int pending();
            return expected_headings.size();
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_heading(bit [atan2h_pkg::OUT_TDATA_W-1:0] word);
            bit [14:0] want;
            if (expected_headings.size() == 0) begin
                report($sformatf("heading %0d arrived with nothing expected", word[14:0]));
            end else begin
                want = expected_headings.pop_front();
                headings_checked++;
                if (word[14:0] !== want)
                    report($sformatf("heading got %0d want %0d", word[14:0], want));
                if (word[atan2h_pkg::OUT_TDATA_W-1:15] !== '0)
                    report($sformatf("padding bits not zero: %h", word));
            end
        endtask
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               s_valid = 1'b0;
    logic [atan2h_pkg::IN_TDATA_W-1:0]  s_data = '0;
    logic                               m_ready = 1'b0;
    logic                               o_s_axis_tready;
    logic                               o_m_axis_tvalid;
    logic [atan2h_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned holds_requested = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;

    heading_scoreboard sb = new();

    atan2_heading_approx_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // clock
    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // receiver ready, with an occasional long hold counted here
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_requested) begin
            m_ready      <= 1'b0;
            hold_left    <= LONG_HOLD - 1;
            holds_served <= holds_served + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // output transfers, sampled mid-cycle when everything has settled
    always @(negedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready)
            sb.check_heading(o_m_axis_tdata);
    end

    // offer one vector, with random gaps ahead of it
    task automatic send_vector(input logic [15:0] ns_raw, input logic [15:0] ew_raw);
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {ew_raw, ns_raw};
        do begin
            @(negedge i_clk);
            taken = o_s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        sb.note_vector(ns_raw, ew_raw);
    endtask

    // stop offering and wait for every expected heading
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [15:0] extreme_component();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h8001;
            3: return 16'h0001;
            4: return 16'hFFFF;
            default: return 16'h0000;
        endcase
    endfunction

    // random vector, biased toward small, axis, diagonal and extreme values
    task automatic send_random_vector();
        t_shape      shape;
        logic [15:0] ns_raw;
        logic [15:0] ew_raw;
        int unsigned pick;
        pick = $urandom_range(9);
        shape = (pick < 5) ? SHAPE_ANY :
                (pick == 5) ? SHAPE_SMALL :
                (pick == 6) ? SHAPE_AXIS :
                (pick < 9) ? SHAPE_NEAR_DIAG : SHAPE_EXTREME;
        ns_raw = $urandom;
        ew_raw = $urandom;
        case (shape)
            SHAPE_SMALL: begin
                ns_raw = 16'($urandom_range(16)) - 16'd8;
                ew_raw = 16'($urandom_range(16)) - 16'd8;
            end
            SHAPE_AXIS: begin
                if ($urandom_range(1))
                    ns_raw = '0;
                else
                    ew_raw = '0;
            end
            SHAPE_NEAR_DIAG: begin
                ns_raw = 16'($urandom_range(32767));
                ew_raw = ns_raw + 16'($urandom_range(6)) - 16'd3;
                if ($urandom_range(1))
                    ns_raw = -ns_raw;
                if ($urandom_range(1))
                    ew_raw = -ew_raw;
            end
            SHAPE_EXTREME: begin
                ns_raw = extreme_component();
                if ($urandom_range(1))
                    ew_raw = extreme_component();
            end
            default: ;
        endcase
        send_vector(ns_raw, ew_raw);
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_random_vector();
        drain_pipeline();
    endtask

    // run limit
    initial begin
        #RUN_LIMIT_NS;
        $display("timeout with %0d headings outstanding", sb.pending());
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero, axes, diagonals, most negative, wrap at full turn
        send_vector(16'h0000, 16'h0000);
        send_vector(16'h7FFF, 16'h0000);
        send_vector(16'h8000, 16'h0000);
        send_vector(16'h0000, 16'h7FFF);
        send_vector(16'h0000, 16'h8000);
        send_vector(16'd100, 16'd100);
        send_vector(16'd100, -16'd100);
        send_vector(-16'd100, 16'd100);
        send_vector(-16'd100, -16'd100);
        send_vector(16'h8000, 16'h8000);
        send_vector(16'h7FFF, 16'h7FFF);
        send_vector(16'h8000, 16'h7FFF);
        send_vector(16'h7FFF, 16'h8000);
        send_vector(16'h7FFF, 16'hFFFF);
        send_vector(16'h7FFF, 16'h0001);
        send_vector(16'h8000, 16'h0001);
        send_vector(16'h8000, 16'hFFFF);
        send_vector(16'h0001, 16'h7FFF);
        send_vector(16'hFFFF, 16'h8000);
        send_vector(16'h0001, 16'h0001);
        send_vector(16'hFFFF, 16'h0001);
        send_vector(16'h0001, 16'h0002);
        drain_pipeline();

        // random traffic under different idle patterns
        run_phase(0, 0, ITEMS_PER_PHASE);
        run_phase(87, 0, ITEMS_PER_PHASE);
        run_phase(0, 87, ITEMS_PER_PHASE);
        run_phase(11, 11, ITEMS_PER_PHASE);

        // long receiver hold while the sender keeps pushing
        @(negedge i_clk);
        holds_requested = holds_requested + 1;
        @(posedge i_clk);
        run_phase(0, 0, HOLD_ITEMS);

        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d headings never arrived", sb.pending()));

        $display("%0d vectors sent, %0d headings checked: axis, diagonal, wrap and extreme",
                 sb.vectors_noted, sb.headings_checked);
        $display("cases plus random traffic with sender gaps, receiver stalls and a long hold");
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
